// ===== sv/kcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcs_pkg
// Types and constants shared by the keyframe channel sampler modules.
// ----------------------------------------------------------------------------
package kcs_pkg;

    // command codes
    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_APPEND  = 2'd1;
    localparam logic [1:0] CMD_TRIGGER = 2'd2;
    localparam logic [1:0] CMD_TICK    = 2'd3;

    // shared divider geometry: 48-bit scaled numerator plus one guard bit
    localparam int DVD_W     = 49;
    localparam int DIV_STEPS = 49;
    localparam int CNT_W     = 6;

    // weight saturates to +/- 1.0 * 2^14 in Q16.16
    localparam logic [48:0] W_LIMIT = 49'h0_0000_4000_0000;

    typedef struct packed {
        logic [1:0]         command;
        logic [31:0]        key_time;
        logic [31:0]        delta_time;
        logic signed [31:0] key_x;
        logic signed [31:0] key_y;
        logic signed [31:0] key_z;
        logic signed [31:0] key_w;
    } item_t;

    typedef struct packed {
        logic               sample_valid;
        logic               still_playing;
        logic [31:0]        clock_now;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
    } result_t;

    // one stored keyframe; val[0] is x through val[3] is w
    typedef struct packed {
        logic [31:0]      ktime;
        logic [3:0][31:0] val;
    } key_entry_t;

    // controller to datapath commands
    typedef struct packed {
        logic emit_idle;
        logic clock_direct;
        logic mod_load;
        logic div_step;
        logic clock_mod;
        logic scan_first;
        logic load_prev;
        logic idx_inc;
        logic load_cur;
        logic wt_load;
        logic wt_zero;
        logic wt_finish;
        logic lerp_mul;
        logic lerp_add;
        logic comp_inc;
        logic emit_prev;
        logic emit_lerp;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic inactive;
        logic need_mod;
        logic div_done;
        logic single_key;
        logic hit;
        logic last_idx;
        logic den_zero;
        logic comp_last;
    } dp_status_t;

endpackage

// ===== sv/keyframe_channel_sampler_core.sv =====
`timescale 1ns / 1ps
// Clear, append and trigger take effect at the accept edge, give no item, busy stays low.
// A tick holds busy only for the check when no sample is due. Otherwise a loop clock that
// wraps first goes through the divider; a single key is then read, a clock past the last
// key reads every key, and a clock in a segment reads up to it, divides unless t1 equals t0
// and lerps each component. The result strobe rises as busy drops and cannot be stalled.
// Reset clears the table count, duration, clock, playing flag and loop mode; no clearing pass.
// ----------------------------------------------------------------------------
// keyframe_channel_sampler_core
// Samples one keyframe animation channel by linear interpolation.
// ----------------------------------------------------------------------------
module keyframe_channel_sampler_core import kcs_pkg::*; #(
    parameter int MAX_KEYS = 64
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    done,
    output result_t result,
    input  logic    cfg_we,
    input  logic    cfg_data
);

    ctrl_cmd_t  ctrl;
    dp_status_t status;
    logic       accept;

    // item handshake
    assign accept = start && !busy;

    kcs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .command(item.command),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    kcs_datapath #(
        .MAX_KEYS(MAX_KEYS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (item),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data),
        .ctrl    (ctrl),
        .status  (status),
        .result  (result),
        .done    (done)
    );

endmodule

// ===== sv/kcs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcs_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kcs_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/kcs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcs_ctrl
// Sequencer for a tick: clock update, keyframe scan, weight divide, lerp.
// ----------------------------------------------------------------------------
module kcs_ctrl import kcs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] command,
    input  dp_status_t status,
    output ctrl_cmd_t  ctrl,
    output logic       busy
);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_CHECK  = 13'b0000000000010,
        ST_MOD    = 13'b0000000000100,
        ST_SADDR0 = 13'b0000000001000,
        ST_SDATA0 = 13'b0000000010000,
        ST_SADDR  = 13'b0000000100000,
        ST_SDATA  = 13'b0000001000000,
        ST_SEMIT  = 13'b0000010000000,
        ST_WLOAD  = 13'b0000100000000,
        ST_WDIV   = 13'b0001000000000,
        ST_LMUL   = 13'b0010000000000,
        ST_LADD   = 13'b0100000000000,
        ST_LEMIT  = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && command == CMD_TICK)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.inactive)
                begin
                    ctrl.emit_idle = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (status.need_mod)
                begin
                    ctrl.mod_load = 1'b1;
                    state_next    = ST_MOD;
                end
                else
                begin
                    ctrl.clock_direct = 1'b1;
                    ctrl.scan_first   = 1'b1;
                    state_next        = ST_SADDR0;
                end
            end
            ST_MOD:
            begin
                if (status.div_done)
                begin
                    ctrl.clock_mod  = 1'b1;
                    ctrl.scan_first = 1'b1;
                    state_next      = ST_SADDR0;
                end
                else
                begin
                    ctrl.div_step = 1'b1;
                end
            end
            ST_SADDR0:
            begin
                state_next = ST_SDATA0;
            end
            ST_SDATA0:
            begin
                ctrl.load_prev = 1'b1;
                if (status.single_key)
                begin
                    state_next = ST_SEMIT;
                end
                else
                begin
                    ctrl.idx_inc = 1'b1;
                    state_next   = ST_SADDR;
                end
            end
            ST_SADDR:
            begin
                state_next = ST_SDATA;
            end
            ST_SDATA:
            begin
                if (status.hit)
                begin
                    ctrl.load_cur = 1'b1;
                    state_next    = ST_WLOAD;
                end
                else if (status.last_idx)
                begin
                    ctrl.load_prev = 1'b1;
                    state_next     = ST_SEMIT;
                end
                else
                begin
                    ctrl.load_prev = 1'b1;
                    ctrl.idx_inc   = 1'b1;
                    state_next     = ST_SADDR;
                end
            end
            ST_SEMIT:
            begin
                ctrl.emit_prev = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_WLOAD:
            begin
                if (status.den_zero)
                begin
                    ctrl.wt_zero = 1'b1;
                    state_next   = ST_LMUL;
                end
                else
                begin
                    ctrl.wt_load = 1'b1;
                    state_next   = ST_WDIV;
                end
            end
            ST_WDIV:
            begin
                if (status.div_done)
                begin
                    ctrl.wt_finish = 1'b1;
                    state_next     = ST_LMUL;
                end
                else
                begin
                    ctrl.div_step = 1'b1;
                end
            end
            ST_LMUL:
            begin
                ctrl.lerp_mul = 1'b1;
                state_next    = ST_LADD;
            end
            ST_LADD:
            begin
                ctrl.lerp_add = 1'b1;
                if (status.comp_last)
                begin
                    state_next = ST_LEMIT;
                end
                else
                begin
                    ctrl.comp_inc = 1'b1;
                    state_next    = ST_LMUL;
                end
            end
            ST_LEMIT:
            begin
                ctrl.emit_lerp = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== sv/kcs_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcs_datapath
// Keyframe table, play clock, shared restoring divider and lerp multiplier.
// ----------------------------------------------------------------------------
module kcs_datapath import kcs_pkg::*; #(
    parameter int MAX_KEYS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  item_t      item,
    input  logic       cfg_we,
    input  logic       cfg_data,
    input  ctrl_cmd_t  ctrl,
    output dp_status_t status,
    output result_t    result,
    output logic       done
);

    localparam int AW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW    = $clog2(MAX_KEYS + 1);
    localparam int KEY_W = $bits(key_entry_t);

    // configuration and channel state
    logic          loop_mode_reg;
    logic [CW-1:0] key_count_reg;
    logic [31:0]   duration_reg;
    logic [31:0]   play_clock_reg;
    logic          playing_reg;
    logic [31:0]   delta_reg;

    // scan state
    logic [AW-1:0] idx_reg;
    key_entry_t    prev_reg;
    key_entry_t    cur_reg;
    key_entry_t    rd_entry;
    key_entry_t    wr_entry;

    // divider state
    logic [DVD_W-1:0] dvd_reg;
    logic [32:0]      rem_reg;
    logic [32:0]      dvs_reg;
    logic [CNT_W-1:0] div_cnt_reg;
    logic             wsign_reg;

    // lerp state
    logic signed [31:0] w_reg;
    logic [1:0]         comp_reg;
    logic signed [64:0] prod_reg;
    logic [3:0][31:0]   res_reg;

    // output
    result_t result_reg;
    logic    done_reg;

    logic               ram_we;
    logic [32:0]        sum;
    logic [33:0]        rem_sh;
    logic               rem_ge;
    logic [33:0]        rem_sub;
    logic signed [32:0] num;
    logic signed [32:0] den;
    logic [31:0]        num_mag;
    logic [31:0]        den_mag;
    logic [48:0]        w_mag;
    logic signed [31:0] w_pos;
    logic signed [32:0] diff;
    logic signed [65:0] lerp_sum;
    logic [31:0]        lerp_res;

    // keyframe storage
    assign ram_we = accept && item.command == CMD_APPEND
                    && key_count_reg != CW'(MAX_KEYS);
    assign wr_entry.ktime  = item.key_time;
    assign wr_entry.val[0] = item.key_x;
    assign wr_entry.val[1] = item.key_y;
    assign wr_entry.val[2] = item.key_z;
    assign wr_entry.val[3] = item.key_w;

    kcs_ram #(
        .WIDTH(KEY_W),
        .DEPTH(MAX_KEYS)
    ) u_key_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(key_count_reg[AW-1:0]),
        .wdata(wr_entry),
        .raddr(idx_reg),
        .rdata(rd_entry)
    );

    // clock sum and divider step
    assign sum     = {1'b0, play_clock_reg} + {1'b0, delta_reg};
    assign rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    // segment numerator and denominator
    assign num     = $signed({1'b0, play_clock_reg}) - $signed({1'b0, prev_reg.ktime});
    assign den     = $signed({1'b0, cur_reg.ktime}) - $signed({1'b0, prev_reg.ktime});
    assign num_mag = num[32] ? 32'(-num) : num[31:0];
    assign den_mag = den[32] ? 32'(-den) : den[31:0];

    // saturated weight magnitude
    assign w_mag = (dvd_reg > W_LIMIT) ? W_LIMIT : dvd_reg;
    assign w_pos = $signed(w_mag[31:0]);

    // lerp terms
    assign diff     = $signed({prev_reg.val[comp_reg][31], prev_reg.val[comp_reg]});
    assign lerp_sum = 66'($signed(prev_reg.val[comp_reg])) + 66'(prod_reg >>> 16);
    always_comb
    begin
        if (lerp_sum > 66'sd2147483647)
        begin
            lerp_res = 32'h7FFF_FFFF;
        end
        else if (lerp_sum < -66'sd2147483648)
        begin
            lerp_res = 32'h8000_0000;
        end
        else
        begin
            lerp_res = lerp_sum[31:0];
        end
    end

    // status to controller
    assign status.inactive   = !playing_reg || key_count_reg == '0 || duration_reg == '0;
    assign status.need_mod   = loop_mode_reg && sum > {1'b0, duration_reg};
    assign status.div_done   = div_cnt_reg == '0;
    assign status.single_key = key_count_reg == CW'(1);
    assign status.hit        = play_clock_reg < rd_entry.ktime;
    assign status.last_idx   = CW'(idx_reg) == key_count_reg - CW'(1);
    assign status.den_zero   = den == '0;
    assign status.comp_last  = comp_reg == 2'd3;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_mode_reg  <= 1'b0;
            key_count_reg  <= '0;
            duration_reg   <= '0;
            play_clock_reg <= '0;
            playing_reg    <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                loop_mode_reg <= cfg_data;
            end
            if (accept && item.command == CMD_CLEAR)
            begin
                key_count_reg <= '0;
                duration_reg  <= '0;
            end
            if (ram_we)
            begin
                key_count_reg <= key_count_reg + CW'(1);
                if (item.key_time > duration_reg)
                begin
                    duration_reg <= item.key_time;
                end
            end
            if (accept && item.command == CMD_TRIGGER)
            begin
                play_clock_reg <= '0;
                playing_reg    <= 1'b1;
            end
            if (ctrl.clock_direct)
            begin
                if (!loop_mode_reg && sum >= {1'b0, duration_reg})
                begin
                    play_clock_reg <= duration_reg;
                    playing_reg    <= 1'b0;
                end
                else
                begin
                    play_clock_reg <= sum[31:0];
                end
            end
            if (ctrl.clock_mod)
            begin
                play_clock_reg <= rem_reg[31:0];
            end
            done_reg <= ctrl.emit_idle || ctrl.emit_prev || ctrl.emit_lerp;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            delta_reg <= item.delta_time;
        end
        // scan
        if (ctrl.scan_first)
        begin
            idx_reg <= '0;
        end
        if (ctrl.idx_inc)
        begin
            idx_reg <= idx_reg + AW'(1);
        end
        if (ctrl.load_prev)
        begin
            prev_reg <= rd_entry;
        end
        if (ctrl.load_cur)
        begin
            cur_reg <= rd_entry;
        end
        // divider
        if (ctrl.mod_load)
        begin
            dvd_reg     <= DVD_W'(sum);
            dvs_reg     <= {1'b0, duration_reg};
            rem_reg     <= '0;
            div_cnt_reg <= CNT_W'(DIV_STEPS);
        end
        if (ctrl.wt_load)
        begin
            dvd_reg     <= {1'b0, num_mag, 16'h0000};
            dvs_reg     <= {1'b0, den_mag};
            rem_reg     <= '0;
            div_cnt_reg <= CNT_W'(DIV_STEPS);
            wsign_reg   <= num[32] ^ den[32];
        end
        if (ctrl.div_step)
        begin
            rem_reg     <= rem_ge ? rem_sub[32:0] : rem_sh[32:0];
            dvd_reg     <= {dvd_reg[DVD_W-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg - CNT_W'(1);
        end
        // weight
        if (ctrl.wt_zero)
        begin
            w_reg <= '0;
        end
        if (ctrl.wt_finish)
        begin
            w_reg <= wsign_reg ? -w_pos : w_pos;
        end
        if (ctrl.wt_zero || ctrl.wt_load)
        begin
            comp_reg <= '0;
        end
        // lerp, one component at a time
        if (ctrl.lerp_mul)
        begin
            prod_reg <= 65'($signed({cur_reg.val[comp_reg][31], cur_reg.val[comp_reg]}) - diff)
                        * 65'(w_reg);
        end
        if (ctrl.lerp_add)
        begin
            res_reg[comp_reg] <= lerp_res;
        end
        if (ctrl.comp_inc)
        begin
            comp_reg <= comp_reg + 2'd1;
        end
        // result
        if (ctrl.emit_idle)
        begin
            result_reg.sample_valid  <= 1'b0;
            result_reg.still_playing <= playing_reg;
            result_reg.clock_now     <= play_clock_reg;
            result_reg.out_x         <= '0;
            result_reg.out_y         <= '0;
            result_reg.out_z         <= '0;
            result_reg.out_w         <= '0;
        end
        if (ctrl.emit_prev)
        begin
            result_reg.sample_valid  <= 1'b1;
            result_reg.still_playing <= playing_reg;
            result_reg.clock_now     <= play_clock_reg;
            result_reg.out_x         <= prev_reg.val[0];
            result_reg.out_y         <= prev_reg.val[1];
            result_reg.out_z         <= prev_reg.val[2];
            result_reg.out_w         <= prev_reg.val[3];
        end
        if (ctrl.emit_lerp)
        begin
            result_reg.sample_valid  <= 1'b1;
            result_reg.still_playing <= playing_reg;
            result_reg.clock_now     <= play_clock_reg;
            result_reg.out_x         <= res_reg[0];
            result_reg.out_y         <= res_reg[1];
            result_reg.out_z         <= res_reg[2];
            result_reg.out_w         <= res_reg[3];
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

// ===== tb/keyframe_channel_sampler_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_channel_sampler_core_tb
// Drives table loads, triggers and ticks into the sampler and compares each
// sample with a predicted sample from a behavioral copy of the channel.
// Runs one-shot and loop settings under several sender gap rates.
// ----------------------------------------------------------------------------
module keyframe_channel_sampler_core_tb;
    import kcs_pkg::*;

    localparam int KEY_DEPTH  = 64;
    localparam int SETTLE_CYC = 400;
    localparam int STALL_MAX  = 20000;

    // ------------------------------------------------------------------------
    // predicted channel state and pending samples
    // ------------------------------------------------------------------------
    class sample_scoreboard;
        logic [31:0]        times [KEY_DEPTH];
        logic signed [31:0] vals  [KEY_DEPTH][4];
        int                 count;
        logic [31:0]        dur;
        logic [31:0]        play_clk;
        logic               playing;
        logic               loop_on;
        result_t            pending_samples[$];
        int                 errors;
        int                 checked;
        int                 valid_seen;

        function new();
            count = 0; dur = 0; play_clk = 0; playing = 0; loop_on = 0;
            errors = 0; checked = 0; valid_seen = 0;
        endfunction

        function longint seg_wt(logic [31:0] c, logic [31:0] t0, logic [31:0] t1);
            longint den;
            longint num;
            longint w;
            den = longint'(t1) - longint'(t0);
            num = longint'(c) - longint'(t0);
            if (den == 0)
                return 0;
            w = (num * 65536) / den;
            if (w > 64'sh4000_0000) w = 64'sh4000_0000;
            if (w < -64'sh4000_0000) w = -64'sh4000_0000;
            return w;
        endfunction

        function logic signed [31:0] lerp(logic signed [31:0] v0,
                                          logic signed [31:0] v1, longint w);
            longint diff;
            longint prod;
            longint q;
            longint r;
            diff = longint'(v1) - longint'(v0);
            prod = diff * w;
            q = prod / 65536;
            if ((prod % 65536) != 0 && prod < 0)
                q = q - 1;
            r = longint'(v0) + q;
            if (r > 64'sh7fff_ffff) r = 64'sh7fff_ffff;
            if (r < -64'sh8000_0000) r = -64'sh8000_0000;
            return r[31:0];
        endfunction

        // note one accepted item; ticks queue a predicted sample
        function void note_item(item_t it);
            result_t     s;
            logic [32:0] sum;
            longint      w;
            int          seg;
            s = '0;
            case (it.command)
                CMD_CLEAR:
                begin
                    count = 0;
                    dur = 0;
                end
                CMD_APPEND:
                begin
                    if (count < KEY_DEPTH)
                    begin
                        times[count] = it.key_time;
                        vals[count][0] = it.key_x;
                        vals[count][1] = it.key_y;
                        vals[count][2] = it.key_z;
                        vals[count][3] = it.key_w;
                        count++;
                        if (it.key_time > dur)
                            dur = it.key_time;
                    end
                end
                CMD_TRIGGER:
                begin
                    play_clk = 0;
                    playing = 1;
                end
                default:
                begin
                    if (playing && count > 0 && dur > 0)
                    begin
                        sum = {1'b0, play_clk} + {1'b0, it.delta_time};
                        if (!loop_on)
                        begin
                            if (sum >= {1'b0, dur})
                            begin
                                play_clk = dur;
                                playing = 0;
                            end
                            else
                                play_clk = sum[31:0];
                        end
                        else if (sum > {1'b0, dur})
                            play_clk = 32'(sum % dur);
                        else
                            play_clk = sum[31:0];
                        s.sample_valid = 1;
                        seg = -1;
                        if (count > 1)
                        begin
                            for (int i = 0; i + 1 < count; i++)
                            begin
                                if (play_clk < times[i + 1])
                                begin
                                    seg = i;
                                    break;
                                end
                            end
                        end
                        if (count == 1)
                        begin
                            s.out_x = vals[0][0]; s.out_y = vals[0][1];
                            s.out_z = vals[0][2]; s.out_w = vals[0][3];
                        end
                        else if (seg < 0)
                        begin
                            s.out_x = vals[count - 1][0]; s.out_y = vals[count - 1][1];
                            s.out_z = vals[count - 1][2]; s.out_w = vals[count - 1][3];
                        end
                        else
                        begin
                            w = seg_wt(play_clk, times[seg], times[seg + 1]);
                            s.out_x = lerp(vals[seg][0], vals[seg + 1][0], w);
                            s.out_y = lerp(vals[seg][1], vals[seg + 1][1], w);
                            s.out_z = lerp(vals[seg][2], vals[seg + 1][2], w);
                            s.out_w = lerp(vals[seg][3], vals[seg + 1][3], w);
                        end
                    end
                    s.still_playing = playing;
                    s.clock_now = play_clk;
                    pending_samples = {pending_samples, s};
                end
            endcase
        endfunction

        function void cmp_field(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a)
            begin
                $display("%0t mismatch %s expected %h actual %h", $time, name, e, a);
                errors++;
            end
        endfunction

        // compare one strobed sample with the oldest prediction
        function void check_result(result_t r);
            result_t e;
            if (pending_samples.size() == 0)
            begin
                $display("%0t unexpected sample expected none actual %h", $time, r);
                errors++;
                return;
            end
            e = pending_samples.pop_front();
            checked++;
            if (e.sample_valid)
                valid_seen++;
            cmp_field("sample_valid", 32'(e.sample_valid), 32'(r.sample_valid));
            cmp_field("still_playing", 32'(e.still_playing), 32'(r.still_playing));
            cmp_field("clock_now", e.clock_now, r.clock_now);
            cmp_field("out_x", e.out_x, r.out_x);
            cmp_field("out_y", e.out_y, r.out_y);
            cmp_field("out_z", e.out_z, r.out_z);
            cmp_field("out_w", e.out_w, r.out_w);
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    done;
    result_t result;
    logic    cfg_we;
    logic    cfg_data;

    sample_scoreboard sb;
    int gap_pct;
    int stall_cnt;
    int sent;

    keyframe_channel_sampler_core #(.MAX_KEYS(KEY_DEPTH)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // sample checker
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    // watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_MAX)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // send one item, with random sender gaps before it
    task automatic send_item(item_t it);
        bit taken;
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        taken = 0;
        while (!taken)
        begin
            @(posedge clk);
            if (!busy)
            begin
                taken = 1;
                sb.note_item(it);
                sent++;
            end
        end
    endtask

    task automatic send_cmd(logic [1:0] c, logic [31:0] t, logic [31:0] d,
                            logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [31:0] w);
        item_t it;
        it.command = c; it.key_time = t; it.delta_time = d;
        it.key_x = x; it.key_y = y; it.key_z = z; it.key_w = w;
        send_item(it);
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(3))
            0: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    // wait for all samples plus the longest tick, then write loop mode
    task automatic idle_and_config(logic mode);
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= mode;
        @(negedge clk);
        cfg_we   <= 1'b0;
        sb.loop_on = mode;
    endtask

    // one play sequence with random content: an optional load, an optional trigger, then ticks
    task automatic play_sequence();
        int          nkeys;
        int          nticks;
        logic [31:0] t;
        logic [31:0] d;
        int          kind;
        kind = $urandom_range(99);
        if (kind < 85)
        begin
            send_cmd(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            nkeys = (kind < 4) ? $urandom_range(66, 62) : $urandom_range(6, 1);
            t = ($urandom_range(3) == 0) ? 0 : $urandom_range(32'h2_0000);
            for (int k = 0; k < nkeys; k++)
            begin
                send_cmd(CMD_APPEND, t, $urandom, rand_val(), rand_val(), rand_val(),
                         rand_val());
                case ($urandom_range(9))
                    0: t = t;
                    1: t = t - $urandom_range(32'h1_0000);
                    2: t = $urandom;
                    default: t = t + $urandom_range(32'h3_0000, 1);
                endcase
            end
        end
        else if (kind < 92)
            send_cmd(CMD_APPEND, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(9) != 0)
            send_cmd(CMD_TRIGGER, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        nticks = $urandom_range(6, 1);
        for (int k = 0; k < nticks; k++)
        begin
            case ($urandom_range(9))
                0: d = 0;
                1: d = $urandom;
                2: d = 32'hffff_ffff;
                default: d = $urandom_range((sb.dur >> 1) + 1);
            endcase
            send_cmd(CMD_TICK, $urandom, d, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    // main stimulus
    initial
    begin
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_data = 1'b0;
        gap_pct = 0;
        stall_cnt = 0;
        sent = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        idle_and_config(1'b0);

        // directed: empty table, zero duration, single key, extremes, equal times
        send_cmd(CMD_TICK, 0, 32'h1_0000, 0, 0, 0, 0);
        send_cmd(CMD_TRIGGER, 0, 0, 0, 0, 0, 0);
        send_cmd(CMD_TICK, 0, 32'h1_0000, 0, 0, 0, 0);
        send_cmd(CMD_APPEND, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0);
        send_cmd(CMD_TICK, 0, 32'h1_0000, 0, 0, 0, 0);
        send_cmd(CMD_APPEND, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                 0, 32'hffff_ffff);
        send_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0);
        send_cmd(CMD_TICK, 0, 32'hffff_ffff, 0, 0, 0, 0);
        send_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
        send_cmd(CMD_APPEND, 32'h1_0000, 0, 32'h10_0000, 32'h7fff_ffff, 0, 32'h8000_0000);
        send_cmd(CMD_APPEND, 32'h1_0000, 0, 32'h20_0000, 32'h8000_0000, 5, 32'h7fff_ffff);
        send_cmd(CMD_APPEND, 32'h3_0000, 0, 32'hfff0_0000, 32'h7fff_ffff, 7, 0);
        send_cmd(CMD_TRIGGER, 0, 0, 0, 0, 0, 0);
        send_cmd(CMD_TICK, 0, 32'h8000, 0, 0, 0, 0);
        send_cmd(CMD_TICK, 0, 32'h1_0000, 0, 0, 0, 0);
        send_cmd(CMD_TICK, 0, 32'h8000, 0, 0, 0, 0);
        send_cmd(CMD_TICK, 0, 32'h2_0000, 0, 0, 0, 0);
        send_cmd(CMD_TICK, 0, 32'h1, 0, 0, 0, 0);
        idle_and_config(1'b1);
        send_cmd(CMD_TRIGGER, 0, 0, 0, 0, 0, 0);
        send_cmd(CMD_TICK, 0, 32'h3_0000, 0, 0, 0, 0);
        send_cmd(CMD_TICK, 0, 32'h5_1234, 0, 0, 0, 0);

        // random phases: gap rate goes from 31 to 53 to 0 percent, loop mode alternates
        for (int ph = 0; ph < 6; ph++)
        begin
            idle_and_config(ph[0]);
            gap_pct = (ph < 2) ? 31 : (ph < 4) ? 53 : 0;
            while (sent < 21 + (ph + 1) * 80)
                play_sequence();
        end

        // drain
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        $display("covered %0d items, %0d ticks checked, %0d valid samples",
                 sent, sb.checked, sb.valid_seen);
        $display("one-shot and loop modes under sender gap rates of 31, 53 and 0 percent");
        if (sb.errors == 0 && sb.pending_samples.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== files.f =====
sv/kcs_pkg.sv
sv/kcs_ram.sv
sv/kcs_ctrl.sv
sv/kcs_datapath.sv
sv/keyframe_channel_sampler_core.sv
tb/keyframe_channel_sampler_core_tb.sv
